// File: sv/ccs_pkg.sv
// Shared widths, payload types and the segment case table of the contour cell unit.
package ccs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int XW         = DATA_WIDTH + 2;
    localparam int HW         = DATA_WIDTH + 3;
    localparam int RW         = DATA_WIDTH + 5;
    localparam int QB         = DATA_WIDTH + 2;
    localparam int MW         = 2 * DATA_WIDTH + 7;
    localparam int ASPLIT     = (HW + 1) / 2;
    localparam int LANE_LAT   = QB + 5;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] height_v1;
        logic signed [DATA_WIDTH-1:0] height_v2;
        logic signed [DATA_WIDTH-1:0] height_v3;
        logic signed [DATA_WIDTH-1:0] height_v4;
        logic signed [DATA_WIDTH-1:0] x_low;
        logic signed [DATA_WIDTH-1:0] x_high;
        logic signed [DATA_WIDTH-1:0] y_low;
        logic signed [DATA_WIDTH-1:0] y_high;
        logic signed [DATA_WIDTH-1:0] level;
    } t_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] seg_x_start;
        logic signed [DATA_WIDTH-1:0] seg_y_start;
        logic signed [DATA_WIDTH-1:0] seg_x_end;
        logic signed [DATA_WIDTH-1:0] seg_y_end;
        logic signed [DATA_WIDTH-1:0] seg_level;
        logic                         last_segment;
    } t_result;

    typedef struct packed {
        logic signed [XW-1:0] xa;
        logic signed [XW-1:0] xb;
        logic [HW-1:0]        a;
        logic [HW-1:0]        b;
        logic                 vtx;
    } t_lane_in;

    typedef enum logic [1:0] {
        SG_NEG  = 2'd0,
        SG_ZERO = 2'd1,
        SG_POS  = 2'd2
    } t_sign;

    typedef enum logic [1:0] {
        ROLE_A,
        ROLE_C,
        ROLE_B
    } t_role;

    typedef enum logic [3:0] {
        SEG_NONE    = 4'd0,
        SEG_PA_PC   = 4'd1,
        SEG_PC_PB   = 4'd2,
        SEG_PB_PA   = 4'd3,
        SEG_PA_ECB  = 4'd4,
        SEG_PC_EBA  = 4'd5,
        SEG_PB_EAC  = 4'd6,
        SEG_EAC_ECB = 4'd7,
        SEG_ECB_EBA = 4'd8,
        SEG_EBA_EAC = 4'd9
    } t_seg_case;

    typedef struct packed {
        t_role pa;
        t_role pb;
        t_role ea;
        t_role eb;
    } t_ends;

    localparam t_seg_case CASE_TAB [27] = '{
        SEG_NONE,    SEG_NONE,    SEG_ECB_EBA,
        SEG_NONE,    SEG_PC_PB,   SEG_PC_EBA,
        SEG_EAC_ECB, SEG_PB_EAC,  SEG_EBA_EAC,
        SEG_NONE,    SEG_PB_PA,   SEG_PA_ECB,
        SEG_PA_PC,   SEG_PB_PA,   SEG_PA_PC,
        SEG_PA_ECB,  SEG_PB_PA,   SEG_NONE,
        SEG_EBA_EAC, SEG_PB_EAC,  SEG_EAC_ECB,
        SEG_PC_EBA,  SEG_PC_PB,   SEG_NONE,
        SEG_ECB_EBA, SEG_NONE,    SEG_NONE
    };

    function automatic t_ends case_ends(input t_seg_case c);
        t_ends e;
        case (c)
            SEG_PA_PC:   e = '{ROLE_A, ROLE_A, ROLE_C, ROLE_C};
            SEG_PC_PB:   e = '{ROLE_C, ROLE_C, ROLE_B, ROLE_B};
            SEG_PB_PA:   e = '{ROLE_B, ROLE_B, ROLE_A, ROLE_A};
            SEG_PA_ECB:  e = '{ROLE_A, ROLE_A, ROLE_C, ROLE_B};
            SEG_PC_EBA:  e = '{ROLE_C, ROLE_C, ROLE_B, ROLE_A};
            SEG_PB_EAC:  e = '{ROLE_B, ROLE_B, ROLE_A, ROLE_C};
            SEG_EAC_ECB: e = '{ROLE_A, ROLE_C, ROLE_C, ROLE_B};
            SEG_ECB_EBA: e = '{ROLE_C, ROLE_B, ROLE_B, ROLE_A};
            SEG_EBA_EAC: e = '{ROLE_B, ROLE_A, ROLE_A, ROLE_C};
            default:     e = '{ROLE_A, ROLE_A, ROLE_A, ROLE_A};
        endcase
        return e;
    endfunction

endpackage

// File: sv/ccs_lane.sv
// One coordinate lane: pipelined edge interpolation, exact division and saturation.
module ccs_lane (
    input  logic                                   i_clk,
    input  ccs_pkg::t_lane_in                      i_lane,
    output logic signed [ccs_pkg::DATA_WIDTH-1:0]  o_coord
);

    localparam int DW = ccs_pkg::DATA_WIDTH;
    localparam int XW = ccs_pkg::XW;
    localparam int HW = ccs_pkg::HW;
    localparam int RW = ccs_pkg::RW;
    localparam int QB = ccs_pkg::QB;
    localparam int MW = ccs_pkg::MW;
    localparam int AS = ccs_pkg::ASPLIT;
    localparam int AH = HW - AS;
    localparam int PW = XW + AH + 2;
    localparam int SW = DW + 4;
    localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

    typedef struct packed {
        logic signed [XW:0]   dx;
        logic signed [XW-1:0] k;
        logic                 r;
        logic [HW-1:0]        a;
        logic [HW:0]          d;
    } t_st1;

    typedef struct packed {
        logic signed [PW-1:0] plo;
        logic signed [PW-1:0] phi;
        logic signed [XW-1:0] k;
        logic                 r;
        logic [HW:0]          d;
    } t_st2;

    typedef struct packed {
        logic signed [MW-1:0] m;
        logic signed [XW-1:0] k;
        logic [RW-1:0]        dd;
    } t_st3;

    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [QB-1:0]        nq;
        logic                 neg;
        logic signed [XW-1:0] k;
        logic [RW-1:0]        dd;
    } t_div;

    t_st1 r_s1, n_s1;
    t_st2 r_s2, n_s2;
    t_st3 r_s3, n_s3;
    t_div r_dv [QB+1];
    t_div n_dv [QB+1];
    logic signed [DW-1:0] r_out, n_out;

    always_comb begin
        logic [HW:0]          dsum;
        logic                 vert;
        logic signed [XW:0]   xp1;
        dsum = (HW+1)'(i_lane.a) + (HW+1)'(i_lane.b);
        vert = i_lane.vtx || (dsum == '0);
        xp1  = (XW+1)'(i_lane.xa) + (XW+1)'(1);
        n_s1.dx = (XW+1)'(i_lane.xb) - (XW+1)'(i_lane.xa);
        n_s1.k  = XW'(xp1 >>> 1);
        n_s1.r  = xp1[0];
        n_s1.a  = vert ? '0 : i_lane.a;
        n_s1.d  = vert ? (HW+1)'(1) : dsum;
    end

    always_comb begin
        n_s2.plo = r_s1.dx * $signed({1'b0, r_s1.a[AS-1:0]});
        n_s2.phi = r_s1.dx * $signed({1'b0, r_s1.a[HW-1:AS]});
        n_s2.k   = r_s1.k;
        n_s2.r   = r_s1.r;
        n_s2.d   = r_s1.d;
    end

    always_comb begin
        logic signed [MW-1:0] dterm;
        dterm = r_s2.r ? MW'($signed({1'b0, r_s2.d})) : '0;
        n_s3.m  = (MW'(r_s2.phi) <<< AS) + MW'(r_s2.plo) + dterm;
        n_s3.k  = r_s2.k;
        n_s3.dd = {r_s2.d, 1'b0};
    end

    always_comb begin
        logic [MW-1:0] u;
        logic          neg;
        logic [RW:0]   trial;
        logic          ge;
        neg = r_s3.m[MW-1];
        u   = neg ? (~r_s3.m + MW'(r_s3.dd)) : r_s3.m;
        n_dv[0].rem = u[MW-1:QB];
        n_dv[0].nq  = u[QB-1:0];
        n_dv[0].neg = neg;
        n_dv[0].k   = r_s3.k;
        n_dv[0].dd  = r_s3.dd;
        for (int j = 0; j < QB; j++) begin
            trial = {r_dv[j].rem, r_dv[j].nq[QB-1]};
            ge    = trial >= {1'b0, r_dv[j].dd};
            n_dv[j+1].rem = ge ? RW'(trial - {1'b0, r_dv[j].dd}) : RW'(trial);
            n_dv[j+1].nq  = {r_dv[j].nq[QB-2:0], ge};
            n_dv[j+1].neg = r_dv[j].neg;
            n_dv[j+1].k   = r_dv[j].k;
            n_dv[j+1].dd  = r_dv[j].dd;
        end
    end

    always_comb begin
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        qs  = SW'($signed({1'b0, r_dv[QB].nq}));
        if (r_dv[QB].neg) begin
            qs = -qs;
        end
        sum = SW'(r_dv[QB].k) + qs;
        if (sum > SMAX) begin
            n_out = SMAX[DW-1:0];
        end else if (sum < SMIN) begin
            n_out = SMIN[DW-1:0];
        end else begin
            n_out = sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_s3 <= n_s3;
        for (int j = 0; j <= QB; j++) begin
            r_dv[j] <= n_dv[j];
        end
        r_out <= n_out;
    end

    assign o_coord = r_out;

endmodule

// File: sv/contour_cell_segments_unit.sv
// Top level of the contour cell unit: cell intake, segment issue and four coordinate lanes.
//
// A cell beat is taken when start is high and busy is low. The unit emits zero to four
// segments per cell, one per clock, in triangle order, with last_segment on the final one;
// a cell with no segment emits nothing. The issue stage sets the rate: a cell with two or
// more segments holds it while it drains, and busy rises when the stages before it are
// full as well. A taken cell passes the intake register and the level and case stages
// before issue; each segment then passes the lane registers, the lanes' interpolation
// stages, their division, which yields one quotient bit per stage, and their output
// register. Results appear on o_result for exactly one cycle with o_strobe high and cannot
// be held off; the pipeline never stalls on the output side.
module contour_cell_segments_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ccs_pkg::t_item     i_item,
    output logic               o_strobe,
    output ccs_pkg::t_result   o_result
);

    localparam int DW = ccs_pkg::DATA_WIDTH;
    localparam int XW = ccs_pkg::XW;
    localparam int HW = ccs_pkg::HW;
    localparam int LL = ccs_pkg::LANE_LAT;

    typedef struct packed {
        logic [3:0][DW:0]     diff;
        logic signed [DW-1:0] xl;
        logic signed [DW-1:0] xr;
        logic signed [DW-1:0] yl;
        logic signed [DW-1:0] yr;
        logic signed [DW-1:0] level;
        logic                 inrange;
    } t_rel;

    typedef struct packed {
        logic [3:0][DW:0]           diff;
        logic signed [HW-1:0]       hsum;
        logic signed [DW-1:0]       xl;
        logic signed [DW-1:0]       xr;
        logic signed [DW-1:0]       yl;
        logic signed [DW-1:0]       yr;
        logic signed [DW-1:0]       level;
        logic [3:0]                 mask;
    } t_cell;

    ccs_pkg::t_item     r_s1;
    logic               r_v1;
    t_rel               r_s2, n_s2;
    logic               r_v2;
    t_cell              r_s3, n_s3;
    logic               r_v3;
    ccs_pkg::t_lane_in  r_ln [4];
    ccs_pkg::t_lane_in  n_ln [4];
    logic               r_v4;
    logic               r_last4;
    logic signed [DW-1:0] r_lev4;
    logic               r_pv    [LL];
    logic               r_plast [LL];
    logic signed [DW-1:0] r_plev [LL];
    logic signed [DW-1:0] w_coord [4];

    logic       en1, en2, en3;
    logic       accept;
    logic       emit;
    logic [3:0] low;
    logic       seg_last;

    assign en3    = !r_v3 || ((r_s3.mask & (r_s3.mask - 4'd1)) == 4'd0);
    assign en2    = en3 || !r_v2;
    assign en1    = en2 || !r_v1;
    assign busy   = !en1;
    assign accept = start && !busy;

    always_comb begin
        logic signed [DW:0] d [4];
        logic               any_ge;
        logic               any_le;
        d[0] = (DW+1)'(r_s1.height_v1) - (DW+1)'(r_s1.level);
        d[1] = (DW+1)'(r_s1.height_v2) - (DW+1)'(r_s1.level);
        d[2] = (DW+1)'(r_s1.height_v3) - (DW+1)'(r_s1.level);
        d[3] = (DW+1)'(r_s1.height_v4) - (DW+1)'(r_s1.level);
        any_ge = 1'b0;
        any_le = 1'b0;
        for (int m = 0; m < 4; m++) begin
            n_s2.diff[m] = d[m];
            if (!d[m][DW]) begin
                any_ge = 1'b1;
            end
            if (d[m][DW] || (d[m] == '0)) begin
                any_le = 1'b1;
            end
        end
        n_s2.xl      = r_s1.x_low;
        n_s2.xr      = r_s1.x_high;
        n_s2.yl      = r_s1.y_low;
        n_s2.yr      = r_s1.y_high;
        n_s2.level   = r_s1.level;
        n_s2.inrange = any_ge && any_le;
    end

    always_comb begin
        logic signed [HW-1:0] hs;
        ccs_pkg::t_sign       sc [4];
        ccs_pkg::t_sign       s0;
        logic [4:0]           idx;
        ccs_pkg::t_seg_case   c;
        hs = '0;
        for (int m = 0; m < 4; m++) begin
            hs = hs + HW'($signed(r_s2.diff[m]));
            if (r_s2.diff[m][DW]) begin
                sc[m] = ccs_pkg::SG_NEG;
            end else if (r_s2.diff[m] == '0) begin
                sc[m] = ccs_pkg::SG_ZERO;
            end else begin
                sc[m] = ccs_pkg::SG_POS;
            end
        end
        if (hs[HW-1]) begin
            s0 = ccs_pkg::SG_NEG;
        end else if (hs == '0) begin
            s0 = ccs_pkg::SG_ZERO;
        end else begin
            s0 = ccs_pkg::SG_POS;
        end
        for (int m = 0; m < 4; m++) begin
            idx = 5'(sc[m]) * 5'd9 + 5'(s0) * 5'd3 + 5'(sc[(m + 1) % 4]);
            c   = ccs_pkg::CASE_TAB[idx];
            n_s3.mask[m] = r_s2.inrange && (c != ccs_pkg::SEG_NONE);
        end
        n_s3.diff  = r_s2.diff;
        n_s3.hsum  = hs;
        n_s3.xl    = r_s2.xl;
        n_s3.xr    = r_s2.xr;
        n_s3.yl    = r_s2.yl;
        n_s3.yr    = r_s2.yr;
        n_s3.level = r_s2.level;
    end

    assign emit     = r_v3 && (r_s3.mask != 4'd0);
    assign low      = r_s3.mask & (~r_s3.mask + 4'd1);
    assign seg_last = (r_s3.mask & ~low) == 4'd0;

    function automatic logic [2:0] role_vertex(input ccs_pkg::t_role ro, input logic [1:0] slot);
        logic [2:0] v;
        case (ro)
            ccs_pkg::ROLE_A: v = {1'b0, slot} + 3'd1;
            ccs_pkg::ROLE_B: v = {1'b0, slot + 2'd1} + 3'd1;
            default:         v = 3'd0;
        endcase
        return v;
    endfunction

    always_comb begin
        logic [1:0]           slot;
        logic signed [XW-1:0] xs [5];
        logic signed [XW-1:0] ys [5];
        logic signed [HW-1:0] hg [5];
        logic [HW-1:0]        hm [5];
        logic [4:0]           idx;
        ccs_pkg::t_sign       sa, s0, sb;
        ccs_pkg::t_seg_case   c;
        ccs_pkg::t_ends       e;
        logic [2:0]           pa, pb, ea, eb;
        slot = 2'd0;
        for (int m = 3; m >= 0; m--) begin
            if (r_s3.mask[m]) begin
                slot = 2'(m);
            end
        end
        xs[0] = XW'(r_s3.xl) + XW'(r_s3.xr);
        ys[0] = XW'(r_s3.yl) + XW'(r_s3.yr);
        xs[1] = XW'(r_s3.xl) <<< 1;
        xs[2] = XW'(r_s3.xr) <<< 1;
        xs[3] = XW'(r_s3.xr) <<< 1;
        xs[4] = XW'(r_s3.xl) <<< 1;
        ys[1] = XW'(r_s3.yl) <<< 1;
        ys[2] = XW'(r_s3.yl) <<< 1;
        ys[3] = XW'(r_s3.yr) <<< 1;
        ys[4] = XW'(r_s3.yr) <<< 1;
        hg[0] = r_s3.hsum;
        for (int m = 0; m < 4; m++) begin
            hg[m+1] = HW'($signed(r_s3.diff[m])) <<< 2;
        end
        for (int m = 0; m < 5; m++) begin
            hm[m] = hg[m][HW-1] ? HW'(-hg[m]) : HW'(hg[m]);
        end
        sa = hg[{1'b0, slot} + 3'd1][HW-1] ? ccs_pkg::SG_NEG :
             (hg[{1'b0, slot} + 3'd1] == '0) ? ccs_pkg::SG_ZERO : ccs_pkg::SG_POS;
        s0 = hg[0][HW-1] ? ccs_pkg::SG_NEG :
             (hg[0] == '0) ? ccs_pkg::SG_ZERO : ccs_pkg::SG_POS;
        sb = hg[{1'b0, slot + 2'd1} + 3'd1][HW-1] ? ccs_pkg::SG_NEG :
             (hg[{1'b0, slot + 2'd1} + 3'd1] == '0) ? ccs_pkg::SG_ZERO : ccs_pkg::SG_POS;
        idx = 5'(sa) * 5'd9 + 5'(s0) * 5'd3 + 5'(sb);
        c   = ccs_pkg::CASE_TAB[idx];
        e   = ccs_pkg::case_ends(c);
        pa  = role_vertex(e.pa, slot);
        pb  = role_vertex(e.pb, slot);
        ea  = role_vertex(e.ea, slot);
        eb  = role_vertex(e.eb, slot);
        n_ln[0] = '{xa: xs[pa], xb: xs[pb], a: hm[pa], b: hm[pb], vtx: pa == pb};
        n_ln[1] = '{xa: ys[pa], xb: ys[pb], a: hm[pa], b: hm[pb], vtx: pa == pb};
        n_ln[2] = '{xa: xs[ea], xb: xs[eb], a: hm[ea], b: hm[eb], vtx: ea == eb};
        n_ln[3] = '{xa: ys[ea], xb: ys[eb], a: hm[ea], b: hm[eb], vtx: ea == eb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int j = 0; j < LL; j++) begin
                r_pv[j] <= 1'b0;
            end
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            r_v4    <= emit;
            r_pv[0] <= r_v4;
            for (int j = 1; j < LL; j++) begin
                r_pv[j] <= r_pv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_item;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_s3 <= n_s3;
        end else begin
            r_s3.mask <= r_s3.mask & ~low;
        end
        for (int l = 0; l < 4; l++) begin
            r_ln[l] <= n_ln[l];
        end
        r_last4    <= seg_last;
        r_lev4     <= r_s3.level;
        r_plast[0] <= r_last4;
        r_plev[0]  <= r_lev4;
        for (int j = 1; j < LL; j++) begin
            r_plast[j] <= r_plast[j-1];
            r_plev[j]  <= r_plev[j-1];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        ccs_lane u_lane (
            .i_clk   (i_clk),
            .i_lane  (r_ln[l]),
            .o_coord (w_coord[l])
        );
    end

    assign o_strobe              = r_pv[LL-1];
    assign o_result.seg_x_start  = w_coord[0];
    assign o_result.seg_y_start  = w_coord[1];
    assign o_result.seg_x_end    = w_coord[2];
    assign o_result.seg_y_end    = w_coord[3];
    assign o_result.seg_level    = r_plev[LL-1];
    assign o_result.last_segment = r_plast[LL-1];

endmodule

// File: test/contour_cell_segments_unit_test.sv
// Self-checking testbench for the contour cell unit: directed cells, then random cells.
module contour_cell_segments_unit_test;

    localparam int SEG_LATENCY = ccs_pkg::DATA_WIDTH + 11;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_CELLS = 200;
    localparam logic signed [31:0] MAX_V = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_V = -32'sh7fffffff - 1;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct {
        ccs_pkg::t_item stim;
        bit             quiet;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    ccs_pkg::t_item   i_item;
    logic             o_strobe;
    ccs_pkg::t_result o_result;

    ccs_pkg::t_result pending_segments[$];
    t_row    rows[$];
    int      mismatches = 0;
    int      stall_cycles = 0;
    bit      beat_taken;

    contour_cell_segments_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic ccs_pkg::t_item mk(logic signed [31:0] h1, h2, h3, h4, xl, xh, yl, yh,
                                          lv);
        ccs_pkg::t_item c;
        c = '{h1, h2, h3, h4, xl, xh, yl, yh, lv};
        return c;
    endfunction

    function automatic void add_row(ccs_pkg::t_item c, bit quiet);
        t_row w;
        w.stim  = c;
        w.quiet = quiet;
        rows.insert(rows.size(), w);
    endfunction

    function automatic logic signed [127:0] crossing(longint xa, longint ha, longint xb,
                                                     longint hb);
        logic signed [127:0] a, b, d, d2, n, xaw, xbw;
        a = (ha < 0) ? -ha : ha;
        b = (hb < 0) ? -hb : hb;
        xaw = xa;
        xbw = xb;
        d = a + b;
        if (d == 0) return (xaw + 1) >>> 1;
        n = xaw * b + xbw * a + d;
        d2 = 2 * d;
        if (n < 0) return -((-n + d2 - 1) / d2);
        return n / d2;
    endfunction

    function automatic logic signed [31:0] clip(logic signed [127:0] v);
        if (v > 128'sh7fffffff) return MAX_V;
        if (v < -128'sh80000000) return MIN_V;
        return v[31:0];
    endfunction

    function automatic void predict_segments(ccs_pkg::t_item c);
        int      tab [3][3][3] = '{ '{'{0, 0, 8}, '{0, 2, 5}, '{7, 6, 9}},
                                    '{'{0, 3, 4}, '{1, 3, 1}, '{4, 3, 0}},
                                    '{'{9, 6, 7}, '{5, 2, 0}, '{8, 0, 0}} };
        longint q[5], hgt[5], xs[5], ys[5], lev, lo, hi;
        int      sh[5];
        int      kind, pa, pb, ea, eb, v1, v3, first;
        ccs_pkg::t_result r;
        logic signed [127:0] x1, y1, x2, y2;
        q[1] = c.height_v1; q[2] = c.height_v2; q[3] = c.height_v3; q[4] = c.height_v4;
        lev = c.level;
        lo = q[1]; hi = q[1];
        for (int m = 2; m <= 4; m++) begin
            if (q[m] < lo) lo = q[m];
            if (q[m] > hi) hi = q[m];
        end
        if (lev < lo || lev > hi) return;
        hgt[0] = 0;
        for (int m = 1; m <= 4; m++) begin
            hgt[m] = 4 * (q[m] - lev);
            hgt[0] += q[m] - lev;
        end
        xs[1] = 2 * longint'(c.x_low);  xs[4] = xs[1];
        xs[2] = 2 * longint'(c.x_high); xs[3] = xs[2];
        ys[1] = 2 * longint'(c.y_low);  ys[2] = ys[1];
        ys[3] = 2 * longint'(c.y_high); ys[4] = ys[3];
        xs[0] = longint'(c.x_low) + longint'(c.x_high);
        ys[0] = longint'(c.y_low) + longint'(c.y_high);
        for (int m = 0; m <= 4; m++) sh[m] = (hgt[m] > 0) ? 1 : ((hgt[m] < 0) ? -1 : 0);
        first = pending_segments.size();
        for (int m = 1; m <= 4; m++) begin
            v1 = m;
            v3 = (m != 4) ? m + 1 : 1;
            kind = tab[sh[v1] + 1][sh[0] + 1][sh[v3] + 1];
            case (kind)
                1: begin pa = v1; pb = v1; ea = 0;  eb = 0;  end
                2: begin pa = 0;  pb = 0;  ea = v3; eb = v3; end
                3: begin pa = v3; pb = v3; ea = v1; eb = v1; end
                4: begin pa = v1; pb = v1; ea = 0;  eb = v3; end
                5: begin pa = 0;  pb = 0;  ea = v3; eb = v1; end
                6: begin pa = v3; pb = v3; ea = v1; eb = 0;  end
                7: begin pa = v1; pb = 0;  ea = 0;  eb = v3; end
                8: begin pa = 0;  pb = v3; ea = v3; eb = v1; end
                9: begin pa = v3; pb = v1; ea = v1; eb = 0;  end
                default: continue;
            endcase
            x1 = crossing(xs[pa], (pa == pb) ? 0 : hgt[pa], xs[pb], (pa == pb) ? 0 : hgt[pb]);
            y1 = crossing(ys[pa], (pa == pb) ? 0 : hgt[pa], ys[pb], (pa == pb) ? 0 : hgt[pb]);
            x2 = crossing(xs[ea], (ea == eb) ? 0 : hgt[ea], xs[eb], (ea == eb) ? 0 : hgt[eb]);
            y2 = crossing(ys[ea], (ea == eb) ? 0 : hgt[ea], ys[eb], (ea == eb) ? 0 : hgt[eb]);
            r = '{clip(x1), clip(y1), clip(x2), clip(y2), c.level, 1'b0};
            pending_segments.insert(pending_segments.size(), r);
        end
        if (pending_segments.size() > first)
            pending_segments[pending_segments.size() - 1].last_segment = 1'b1;
    endfunction

    task automatic send_cell(ccs_pkg::t_item c, int gap, bit quiet);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= c;
        do @(posedge i_clk); while (busy);
        if (!quiet) predict_segments(c);
    endtask

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return MAX_V;
            1: return MIN_V;
            2, 3: return $urandom_range(0, 16 * ONE) - 8 * ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic ccs_pkg::t_item random_cell();
        ccs_pkg::t_item c;
        longint lo, hi;
        c = mk(any_value(), any_value(), any_value(), any_value(),
               any_value(), any_value(), any_value(), any_value(), any_value());
        if ($urandom_range(0, 3) == 0) c.height_v2 = c.height_v1;
        if ($urandom_range(0, 9) < 8) begin
            lo = c.height_v1; hi = c.height_v1;
            lo = (c.height_v2 < lo) ? c.height_v2 : lo; hi = (c.height_v2 > hi) ? c.height_v2 : hi;
            lo = (c.height_v3 < lo) ? c.height_v3 : lo; hi = (c.height_v3 > hi) ? c.height_v3 : hi;
            lo = (c.height_v4 < lo) ? c.height_v4 : lo; hi = (c.height_v4 > hi) ? c.height_v4 : hi;
            case ($urandom_range(0, 3))
                0: c.level = c.height_v3;
                1: c.level = 32'(lo + (hi - lo) / 2);
                default: c.level = 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
            endcase
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_segments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected segment %p", o_result);
            end else begin
                if (o_result.seg_x_start !== pending_segments[0].seg_x_start ||
                    o_result.seg_y_start !== pending_segments[0].seg_y_start ||
                    o_result.seg_x_end !== pending_segments[0].seg_x_end ||
                    o_result.seg_y_end !== pending_segments[0].seg_y_end ||
                    o_result.seg_level !== pending_segments[0].seg_level ||
                    o_result.last_segment !== pending_segments[0].last_segment) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("segment mismatch: expected %p, got %p",
                                 pending_segments[0], o_result);
                end
                void'(pending_segments.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        beat_taken = (start && !busy) || o_strobe;
        if (!i_rst_n || beat_taken) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("contour_cell_segments_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        add_row(mk(0, ONE, 2 * ONE, ONE, 0, ONE, 0, ONE, 3 * ONE), 1'b1);
        add_row(mk(0, ONE, 2 * ONE, ONE, 0, ONE, 0, ONE, -ONE), 1'b1);
        add_row(mk(ONE, ONE, ONE, ONE, 0, ONE, 0, ONE, ONE), 1'b0);
        add_row(mk(MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V), 1'b0);
        add_row(mk(MAX_V, MAX_V, MAX_V, MAX_V, 0, 0, 0, 0, MIN_V), 1'b1);
        add_row(mk(0, ONE, 2 * ONE, ONE, 0, ONE, 0, ONE, ONE / 2), 1'b0);
        add_row(mk(0, ONE, 2 * ONE, ONE, 0, ONE, 0, ONE, ONE), 1'b0);
        add_row(mk(0, 0, ONE, ONE, 0, ONE, 0, ONE, 0), 1'b0);
        add_row(mk(ONE, -ONE, ONE, -ONE, 0, ONE, 0, ONE, 0), 1'b0);
        add_row(mk(ONE, -ONE, 2 * ONE, -ONE, 0, ONE, 0, ONE, 0), 1'b0);
        add_row(mk(MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, 0), 1'b0);
        add_row(mk(MIN_V, MAX_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, -1), 1'b0);
        add_row(mk(MAX_V, MIN_V, MIN_V, MIN_V, MAX_V, MAX_V, MIN_V, MIN_V, MAX_V), 1'b0);
        add_row(mk(MIN_V, 0, MAX_V, 0, 5 * ONE, -3 * ONE, 7, -7, MIN_V), 1'b0);
        add_row(mk(-1, 1, -1, 1, -1, 1, -1, 1, 0), 1'b0);
        add_row(mk(0, 0, 0, ONE, -ONE, ONE, -ONE, ONE, 0), 1'b0);
        add_row(mk(ONE, ONE, 0, ONE, 3, 8, 1, 6, ONE), 1'b0);
        add_row(mk(-ONE, 2 * ONE, ONE, -3 * ONE, 0, 10 * ONE, 0, 10 * ONE, 0), 1'b0);
        add_row(mk(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, 32'shEDCB_A987,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                   32'sh0000_0001), 1'b0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send_cell(rows[k].stim, $urandom_range(0, 12), rows[k].quiet);
        for (int k = 0; k < RANDOM_CELLS; k++) begin
            if (k == RANDOM_CELLS / 2) begin
                start <= 1'b0;
                while (pending_segments.size() != 0) @(posedge i_clk);
            end
            send_cell(random_cell(), ((k / 20) % 3 == 0) ? 0 : $urandom_range(0, 12), 1'b0);
        end
        start <= 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (SEG_LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("contour_cell_segments_unit_test: PASS");
        end else begin
            $display("contour_cell_segments_unit_test: FAIL");
        end
        $finish;
    end
endmodule
